FILE: design/trs_pkg.sv
// Shared types and constants for the trace ring with snapshot.
// No dependencies; imported by trs_ram, trace_ring_with_snapshot and the testbench.

package trs_pkg;

    localparam int RING_DEPTH = 256;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = PTR_W + 1;
    localparam int MAX_RUN    = 64;
    localparam int RUN_W      = 7;
    localparam int WORD_W     = 64;
    localparam int TAG_W      = 16;
    localparam int SEQ_W      = 32;
    localparam int OPC_W      = 3;

    localparam logic [OPC_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OPC_W-1:0] OP_READ  = 3'd1;
    localparam logic [OPC_W-1:0] OP_SNAP  = 3'd2;
    localparam logic [OPC_W-1:0] OP_CHUNK = 3'd3;
    localparam logic [OPC_W-1:0] OP_CLEAR = 3'd4;

    // one stored sample
    typedef struct packed {
        logic [WORD_W-1:0] w2;
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] w0;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    // one write port and one read port of a sample store
    typedef struct packed {
        logic             wr_en;
        logic [PTR_W-1:0] wr_addr;
        entry_t           wr_data;
        logic             rd_en;
        logic [PTR_W-1:0] rd_addr;
    } ram_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD_ISSUE,
        ST_RD_DATA,
        ST_SNAP,
        ST_SNAP_DRAIN,
        ST_STATUS
    } state_t;

endpackage

FILE: design/trace_ring_with_snapshot.sv
// Trace ring with snapshot: top level, control sequencer and output register.
// Depends on trs_pkg and two trs_ram instances (live ring, snapshot store).
// Usage
//   Commands arrive on the s_* stream, one transfer per command; s_tuser carries the
//   opcode (push, read latest, take snapshot, read snapshot chunk, clear). Results
//   leave on the m_* stream; m_tlast marks the final result of a command and
//   m_tuser flags a result that carries a sample. Every result also reports the
//   ring and snapshot counters as they stand after the command.
// Sequencing (receiver ready)
//   Commands are accepted only while the sequencer is idle. Push, clear, empty
//   snapshot and reads that return nothing give a status result. A read of n
//   samples makes one memory read and one output load per sample. A snapshot of
//   c entries copies one entry per cycle from the ring read port to the snapshot
//   write port.
// Reset and stall
//   Reset clears all counters and the output valid; the stores are not cleared,
//   and only entries below the live or latched count are ever read.
//   A stalled receiver holds the output register; the sequencer waits in place with
//   the memory read data held, and an idle sequencer still takes a new command
//   while a final result waits.

module trace_ring_with_snapshot
    import trs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // low to high: sample_word0[63:0], sample_word1[127:64], sample_word2[191:128],
    // start_index[200:192], run_limit[207:201], expected_sequence[239:208]
    input  logic [239:0] s_tdata,
    // opcode[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // low to high: sample_word0_res[63:0], sample_word1_res[127:64],
    // sample_word2_res[191:128], sample_index[207:192], copied_count[214:208],
    // ring_fill[223:215], head_position[231:224], write_sequence[263:232],
    // snap_fill[272:264], snapshot_sequence[304:273], zero fill[311:305]
    output logic [311:0] m_tdata,
    // carries_sample[0]
    output logic [0:0]   m_tuser,
    // last_of_run
    output logic         m_tlast
);

    typedef struct packed {
        logic [OPC_W-1:0]  opc;
        logic [WORD_W-1:0] w2;
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] w0;
        logic [CNT_W-1:0]  start;
        logic [RUN_W-1:0]  maxs;
        logic [SEQ_W-1:0]  exp_seq;
    } cmd_t;

    // saturated run length of a read
    function automatic logic [RUN_W-1:0] run_length(
        input logic [CNT_W-1:0] avail,
        input logic [CNT_W-1:0] start,
        input logic [RUN_W-1:0] maxs
    );
        logic [RUN_W-1:0] lim;
        logic [CNT_W-1:0] left;
        lim  = (maxs > RUN_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : maxs;
        left = avail - start;
        if (lim == '0 || start >= avail)
        begin
            return '0;
        end
        else if (left > CNT_W'(lim))
        begin
            return lim;
        end
        else
        begin
            return left[RUN_W-1:0];
        end
    endfunction

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;

    logic [PTR_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [CNT_W-1:0]  lcnt_reg, lcnt_next;
    logic [SEQ_W-1:0]  lseq_reg, lseq_next;

    logic [PTR_W-1:0]  addr_reg, addr_next;
    logic [PTR_W-1:0]  cnt_reg, cnt_next;
    logic [RUN_W-1:0]  run_reg, run_next;
    logic [RUN_W-1:0]  idx_reg, idx_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [PTR_W-1:0]  snap_wa_reg, snap_wa_next;

    logic              out_valid_reg;
    entry_t            out_entry_reg;
    logic              out_carry_reg;
    logic              out_last_reg;
    logic [RUN_W-1:0]  out_copied_reg;
    logic [CNT_W-1:0]  out_live_reg;
    logic [PTR_W-1:0]  out_head_reg;
    logic [SEQ_W-1:0]  out_seq_reg;
    logic [CNT_W-1:0]  out_lcnt_reg;
    logic [SEQ_W-1:0]  out_lseq_reg;

    logic              out_free;
    logic              out_load;
    logic              out_is_sample;
    logic              run_done;
    logic [RUN_W-1:0]  run_n;
    logic [PTR_W-1:0]  oldest;
    ram_req_t          ring_req, snap_req;
    entry_t            ring_rdata, snap_rdata, rd_entry;

    trs_ram u_ring (
        .clk     (clk),
        .req     (ring_req),
        .rd_data (ring_rdata)
    );

    trs_ram u_snap (
        .clk     (clk),
        .req     (snap_req),
        .rd_data (snap_rdata)
    );

    // ring depth is a power of two, so the slot arithmetic wraps in PTR_W bits
    assign oldest   = head_reg - held_reg[PTR_W-1:0];
    assign out_free = !out_valid_reg || m_tready;
    assign run_done = (idx_reg + 1'b1) == run_reg;
    assign rd_entry = (cmd_reg.opc == OP_READ) ? ring_rdata : snap_rdata;

    always_comb
    begin
        if (cmd_reg.opc == OP_READ)
        begin
            run_n = run_length(held_reg, cmd_reg.start, cmd_reg.maxs);
        end
        else if (cmd_reg.exp_seq == lseq_reg)
        begin
            run_n = run_length(lcnt_reg, cmd_reg.start, cmd_reg.maxs);
        end
        else
        begin
            run_n = '0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                priority if (cmd_reg.opc == OP_READ || cmd_reg.opc == OP_CHUNK)
                begin
                    state_next = (run_n != '0) ? ST_RD_ISSUE : ST_STATUS;
                end
                else if (cmd_reg.opc == OP_SNAP)
                begin
                    state_next = (held_reg != '0) ? ST_SNAP : ST_STATUS;
                end
                else
                begin
                    state_next = ST_STATUS;
                end
            end
            ST_RD_ISSUE:
            begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                if (out_free)
                begin
                    state_next = run_done ? ST_IDLE : ST_RD_ISSUE;
                end
            end
            ST_SNAP:
            begin
                if (({1'b0, cnt_reg} + 1'b1) == lcnt_reg)
                begin
                    state_next = ST_SNAP_DRAIN;
                end
            end
            ST_SNAP_DRAIN:
            begin
                state_next = ST_STATUS;
            end
            ST_STATUS:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // handshake, memory ports and output load
    always_comb
    begin
        s_tready      = (state_reg == ST_IDLE);
        out_load      = ((state_reg == ST_STATUS) || (state_reg == ST_RD_DATA)) && out_free;
        out_is_sample = (state_reg == ST_RD_DATA);

        ring_req.wr_en   = (state_reg == ST_EXEC) && (cmd_reg.opc == OP_PUSH);
        ring_req.wr_addr = head_reg;
        ring_req.wr_data = {cmd_reg.w2, cmd_reg.w1, cmd_reg.w0, seq_reg[TAG_W-1:0]};
        ring_req.rd_en   = ((state_reg == ST_RD_ISSUE) && (cmd_reg.opc == OP_READ))
                           || (state_reg == ST_SNAP);
        ring_req.rd_addr = addr_reg;

        // each copy write lands in the cycle after its ring read
        snap_req.wr_en   = wr_pend_reg;
        snap_req.wr_addr = snap_wa_reg;
        snap_req.wr_data = ring_rdata;
        snap_req.rd_en   = (state_reg == ST_RD_ISSUE) && (cmd_reg.opc == OP_CHUNK);
        snap_req.rd_addr = addr_reg;
    end

    // counters and sequencer registers
    always_comb
    begin
        cmd_next     = cmd_reg;
        head_next    = head_reg;
        held_next    = held_reg;
        seq_next     = seq_reg;
        lcnt_next    = lcnt_reg;
        lseq_next    = lseq_reg;
        addr_next    = addr_reg;
        cnt_next     = cnt_reg;
        run_next     = run_reg;
        idx_next     = idx_reg;
        wr_pend_next = 1'b0;
        snap_wa_next = snap_wa_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next.opc     = s_tuser;
                    cmd_next.w0      = s_tdata[63:0];
                    cmd_next.w1      = s_tdata[127:64];
                    cmd_next.w2      = s_tdata[191:128];
                    cmd_next.start   = s_tdata[200:192];
                    cmd_next.maxs    = s_tdata[207:201];
                    cmd_next.exp_seq = s_tdata[239:208];
                end
            end
            ST_EXEC:
            begin
                run_next = run_n;
                idx_next = '0;
                cnt_next = '0;
                priority if (cmd_reg.opc == OP_PUSH)
                begin
                    head_next = head_reg + 1'b1;
                    if (held_reg < CNT_W'(RING_DEPTH))
                    begin
                        held_next = held_reg + 1'b1;
                    end
                    seq_next = seq_reg + 1'b1;
                end
                else if (cmd_reg.opc == OP_READ)
                begin
                    addr_next = oldest + cmd_reg.start[PTR_W-1:0];
                end
                else if (cmd_reg.opc == OP_SNAP)
                begin
                    addr_next = oldest;
                    lcnt_next = held_reg;
                    lseq_next = seq_reg;
                end
                else if (cmd_reg.opc == OP_CHUNK)
                begin
                    addr_next = cmd_reg.start[PTR_W-1:0];
                end
                else if (cmd_reg.opc == OP_CLEAR)
                begin
                    head_next = '0;
                    held_next = '0;
                    seq_next  = '0;
                    lcnt_next = '0;
                    lseq_next = '0;
                end
                else
                begin
                    // unknown opcode: nothing changes
                    run_next = '0;
                end
            end
            ST_SNAP:
            begin
                addr_next    = addr_reg + 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                wr_pend_next = 1'b1;
                snap_wa_next = cnt_reg;
            end
            ST_RD_DATA:
            begin
                if (out_free)
                begin
                    addr_next = addr_reg + 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            ST_RD_ISSUE, ST_SNAP_DRAIN, ST_STATUS:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            held_reg    <= '0;
            seq_reg     <= '0;
            lcnt_reg    <= '0;
            lseq_reg    <= '0;
            addr_reg    <= '0;
            cnt_reg     <= '0;
            run_reg     <= '0;
            idx_reg     <= '0;
            wr_pend_reg <= 1'b0;
            snap_wa_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            held_reg    <= held_next;
            seq_reg     <= seq_next;
            lcnt_reg    <= lcnt_next;
            lseq_reg    <= lseq_next;
            addr_reg    <= addr_next;
            cnt_reg     <= cnt_next;
            run_reg     <= run_next;
            idx_reg     <= idx_next;
            wr_pend_reg <= wr_pend_next;
            snap_wa_reg <= snap_wa_next;
        end
    end

    // command payload, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    // output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_entry_reg  <= out_is_sample ? rd_entry : '0;
            out_carry_reg  <= out_is_sample;
            out_last_reg   <= out_is_sample ? run_done : 1'b1;
            out_copied_reg <= out_is_sample ? run_reg : '0;
            out_live_reg   <= held_reg;
            out_head_reg   <= head_reg;
            out_seq_reg    <= seq_reg;
            out_lcnt_reg   <= lcnt_reg;
            out_lseq_reg   <= lseq_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_carry_reg;
    assign m_tdata    = {7'd0, out_lseq_reg, out_lcnt_reg, out_seq_reg, out_head_reg,
                         out_live_reg, out_copied_reg, out_entry_reg.tag,
                         out_entry_reg.w2, out_entry_reg.w1, out_entry_reg.w0};

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten");

    // snapshot copy and chunk read never share the snapshot store
    a_snap_port: assert property (@(posedge clk) disable iff (!rst_n)
        snap_req.wr_en |-> !snap_req.rd_en)
        else $error("snapshot store written during a chunk read");

    // live count saturates at the ring depth
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(RING_DEPTH))
        else $error("live count beyond ring depth");

    // a sample result is only loaded inside its run
    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_is_sample) |-> (idx_reg < run_reg))
        else $error("sample result beyond run length");

    // a push moves the head by one slot
    a_push_head: assert property (@(posedge clk) disable iff (!rst_n)
        ring_req.wr_en |=> (head_reg == PTR_W'($past(head_reg) + 1'b1)))
        else $error("head not advanced after push");

endmodule

FILE: design/trs_ram.sv
// Sample store: one write port and one registered read port.
// Depends on trs_pkg for entry_t and ram_req_t.

module trs_ram
    import trs_pkg::*;
(
    input  logic     clk,
    input  ram_req_t req,
    output entry_t   rd_data
);

    entry_t mem [RING_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // read data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

FILE: verif/tb_trace_ring_with_snapshot.sv
// Self-checking testbench for trace_ring_with_snapshot: directed and random command
// streams with random idling on both stream sides, checked against a local predictor.
// Depends on trs_pkg and the trace_ring_with_snapshot RTL.
`timescale 1ns / 100ps

module tb_trace_ring_with_snapshot;
    import trs_pkg::*;

    // opcodes the block does not decode; they must leave all state alone
    localparam logic [OPC_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OPC_W-1:0] OP_SPARE_LAST  = 3'd7;

    // Guard: ~330 commands, each at worst 64 results held up by the longest stall,
    // plus the longest send gaps and full-ring snapshots, then taken a few times over.
    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int DRAIN_CYCLES = 300;
    localparam int WRAP_PUSHES  = 260;
    localparam int MIX_COMMANDS = 20;

    // one expected or observed result transfer
    typedef struct packed {
        entry_t             smp;
        logic               carries;
        logic               last;
        logic [RUN_W-1:0]   copied;
        logic [CNT_W-1:0]   live;
        logic [PTR_W-1:0]   head;
        logic [SEQ_W-1:0]   wseq;
        logic [CNT_W-1:0]   scount;
        logic [SEQ_W-1:0]   sseq;
    } trace_result_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           s_tvalid;
    logic           s_tready;
    logic [239:0]   s_tdata;
    logic [2:0]     s_tuser;
    logic           m_tvalid;
    logic           m_tready;
    logic [311:0]   m_tdata;
    logic [0:0]     m_tuser;
    logic           m_tlast;

    // predictor state: live ring, snapshot store and counters
    entry_t         live_store [RING_DEPTH];
    entry_t         snap_store [RING_DEPTH];
    int unsigned    ring_head;
    int unsigned    ring_held;
    logic [31:0]    push_seq;
    int unsigned    snap_held;
    logic [31:0]    snap_seq;

    trace_result_t  pending_results [$];

    // run statistics
    int             mismatch_count;
    int             results_seen;
    int             samples_seen;
    int             cycle_count;
    int             command_count;
    int             push_total;
    int             read_total;
    int             snap_total;
    int             clear_total;
    int             wrap_total;

    // set for stretches where neither side idles
    bit             calm;

    trace_ring_with_snapshot uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Receiver back-pressure: mostly short stalls, occasionally a long one,
    // none at all while calm is set.
    // ---------------------------------------------------------------------
    int stall_left;

    always @(posedge clk)
    begin
        int r;
        if (calm)
        begin
            stall_left = 0;
            m_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                m_tready <= 1'b1;
            else if (r < 95)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end
            else
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(10, 50);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result checker: every accepted result transfer against the oldest
    // expectation.
    // ---------------------------------------------------------------------
    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        if (want !== got)
            $display("    %-9s expected %h, got %h", name, want, got);
    endtask

    always @(posedge clk)
    begin
        trace_result_t want;
        trace_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            got.smp.w0   = m_tdata[63:0];
            got.smp.w1   = m_tdata[127:64];
            got.smp.w2   = m_tdata[191:128];
            got.smp.tag  = m_tdata[207:192];
            got.copied   = m_tdata[214:208];
            got.live     = m_tdata[223:215];
            got.head     = m_tdata[231:224];
            got.wseq     = m_tdata[263:232];
            got.scount   = m_tdata[272:264];
            got.sseq     = m_tdata[304:273];
            got.carries  = m_tuser[0];
            got.last     = m_tlast;
            if (got.carries === 1'b1)
                samples_seen++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0t] unexpected result transfer: %h", $realtime, got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("[%0t] mismatch on result %0d:", $realtime, results_seen);
                        report_field("word0",   want.smp.w0,  got.smp.w0);
                        report_field("word1",   want.smp.w1,  got.smp.w1);
                        report_field("word2",   want.smp.w2,  got.smp.w2);
                        report_field("tag",     64'(want.smp.tag), 64'(got.smp.tag));
                        report_field("carries", 64'(want.carries), 64'(got.carries));
                        report_field("last",    64'(want.last),    64'(got.last));
                        report_field("copied",  64'(want.copied),  64'(got.copied));
                        report_field("live",    64'(want.live),    64'(got.live));
                        report_field("head",    64'(want.head),    64'(got.head));
                        report_field("wseq",    64'(want.wseq),    64'(got.wseq));
                        report_field("scount",  64'(want.scount),  64'(got.scount));
                        report_field("sseq",    64'(want.sseq),    64'(got.sseq));
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------
    function automatic int unsigned run_len(input int unsigned avail,
                                            input int unsigned start,
                                            input int unsigned maxs);
        int unsigned lim;
        lim = (maxs > MAX_RUN) ? MAX_RUN : maxs;
        if (lim == 0 || start >= avail)
            return 0;
        return (avail - start > lim) ? lim : avail - start;
    endfunction

    // queue one expected result; counters as they stand after the command
    task automatic expect_result(input entry_t smp, input bit carries, input bit last,
                                 input int unsigned copied);
        trace_result_t r;
        r.smp     = smp;
        r.carries = carries;
        r.last    = last;
        r.copied  = copied[RUN_W-1:0];
        r.live    = ring_held[CNT_W-1:0];
        r.head    = ring_head[PTR_W-1:0];
        r.wseq    = push_seq;
        r.scount  = snap_held[CNT_W-1:0];
        r.sseq    = snap_seq;
        pending_results.push_back(r);
    endtask

    task automatic apply_command(input logic [2:0] op, input logic [63:0] w0,
                                 input logic [63:0] w1, input logic [63:0] w2,
                                 input logic [8:0] start, input logic [6:0] maxs,
                                 input logic [31:0] seq);
        int unsigned n;
        int unsigned oldest;
        entry_t      blank;
        n = 0;
        blank = '0;
        oldest = (ring_head + RING_DEPTH - ring_held) % RING_DEPTH;
        case (op)
            OP_PUSH:
            begin
                live_store[PTR_W'(ring_head)] = '{w2: w2, w1: w1, w0: w0,
                                                  tag: push_seq[TAG_W-1:0]};
                ring_head = (ring_head + 1) % RING_DEPTH;
                if (ring_head == 0)
                    wrap_total++;
                if (ring_held < RING_DEPTH)
                    ring_held++;
                push_seq++;
            end
            OP_READ:
            begin
                n = run_len(ring_held, start, maxs);
                for (int unsigned i = 0; i < n; i++)
                    expect_result(live_store[PTR_W'((oldest + start + i) % RING_DEPTH)],
                                  1'b1, i + 1 == n, n);
            end
            OP_SNAP:
            begin
                for (int unsigned i = 0; i < ring_held; i++)
                    snap_store[PTR_W'(i)] = live_store[PTR_W'((oldest + i) % RING_DEPTH)];
                snap_held = ring_held;
                snap_seq  = push_seq;
            end
            OP_CHUNK:
            begin
                n = (seq == snap_seq) ? run_len(snap_held, start, maxs) : 0;
                for (int unsigned i = 0; i < n; i++)
                    expect_result(snap_store[PTR_W'((start + i) % RING_DEPTH)], 1'b1,
                                  i + 1 == n, n);
            end
            OP_CLEAR:
            begin
                // stores keep their contents, every counter goes back to zero
                ring_head = 0;
                ring_held = 0;
                push_seq  = '0;
                snap_held = 0;
                snap_seq  = '0;
            end
            default:
            begin
            end
        endcase
        if (n == 0)
            expect_result(blank, 1'b0, 1'b1, 0);
    endtask

    // ---------------------------------------------------------------------
    // Command sender
    // ---------------------------------------------------------------------
    function automatic int next_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one command transfer; the prediction is made once the transfer completes
    task automatic send_command(input logic [2:0] op, input logic [63:0] w0,
                                input logic [63:0] w1, input logic [63:0] w2,
                                input logic [8:0] start, input logic [6:0] maxs,
                                input logic [31:0] seq);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {seq, maxs, start, w2, w1, w0};
        do
            @(posedge clk);
        while (!s_tready);
        command_count++;
        case (op)
            OP_PUSH:            push_total++;
            OP_READ, OP_CHUNK:  read_total++;
            OP_SNAP:            snap_total++;
            OP_CLEAR:           clear_total++;
            default:            ;
        endcase
        apply_command(op, w0, w1, w2, start, maxs, seq);
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // start offsets: mostly inside or just past the held entries
    function automatic logic [8:0] pick_start(input int unsigned avail);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 9'($urandom_range(0, avail));
        else if (r < 85)
            return 9'($urandom_range(0, 511));
        return '0;
    endfunction

    // run lengths: mostly short so the run stays quick
    function automatic logic [6:0] pick_max();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 7'($urandom_range(1, 8));
        else if (r < 75)
            return 7'($urandom_range(0, 127));
        else if (r < 85)
            return '0;
        return 7'(MAX_RUN);
    endfunction

    function automatic logic [31:0] pick_seq();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return snap_seq;
        else if (r < 90)
            return $urandom_range(0, 1) ? snap_seq + 1 : snap_seq - 1;
        return $urandom;
    endfunction

    task automatic send_random_command(input int push_weight, input bit with_clear);
        int             r;
        logic [2:0]     op;
        logic [8:0]     start;
        logic [6:0]     maxs;
        logic [31:0]    seq;
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        start = 9'($urandom_range(0, 511));
        maxs  = 7'($urandom_range(0, 127));
        seq   = $urandom;
        r = $urandom_range(0, 99);
        if (r < push_weight)
            op = OP_PUSH;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                op = OP_READ;
            else if (r < 48)
                op = OP_SNAP;
            else if (r < 85)
                op = OP_CHUNK;
            else if (r < 93)
                op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            else
                op = with_clear ? OP_CLEAR : OP_CHUNK;
        end
        case (op)
            OP_READ:
            begin
                start = pick_start(ring_held);
                maxs  = pick_max();
            end
            OP_CHUNK:
            begin
                start = pick_start(snap_held);
                maxs  = pick_max();
                seq   = pick_seq();
            end
            default:
            begin
            end
        endcase
        send_command(op, rand_word(), rand_word(), rand_word(), start, maxs, seq);
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // everything on an empty ring and an empty snapshot gives a status result
    task automatic test_empty_ring();
        send_command(OP_READ, '0, '0, '0, 9'd0, 7'd64, '0);
        send_command(OP_CHUNK, '0, '0, '0, 9'd0, 7'd64, 32'd0);
        send_command(OP_SNAP, '0, '0, '0, 9'd0, 7'd0, '0);
        send_command(OP_CHUNK, '0, '0, '0, 9'd0, 7'd127, 32'd0);
    endtask

    // payload extremes; the unused fields swing between all ones and all zeros
    task automatic test_push_extremes();
        send_command(OP_PUSH, '1, '1, '1, '1, '1, '1);
        send_command(OP_PUSH, '0, '0, '0, '0, '0, '0);
        send_command(OP_PUSH, {16{4'hA}}, {16{4'h5}}, {16{4'hA}}, 9'h155, 7'h2A, 32'hAAAA_AAAA);
        send_command(OP_PUSH, {16{4'h5}}, {16{4'hA}}, {16{4'h5}}, 9'h0AA, 7'h55, 32'h5555_5555);
    endtask

    // four entries held: zero max, saturating max, tail, start past end
    task automatic test_read_limits();
        send_command(OP_READ, '0, '0, '0, 9'd0, 7'd0, '0);
        send_command(OP_READ, '0, '0, '0, 9'd0, 7'd127, '0);
        send_command(OP_READ, '0, '0, '0, 9'd3, 7'd1, '0);
        send_command(OP_READ, '0, '0, '0, 9'd4, 7'd10, '0);
        send_command(OP_READ, '0, '0, '0, 9'd511, 7'd127, '0);
        send_command(OP_READ, '0, '0, '0, 9'd1, 7'd2, '0);
    endtask

    // snapshot stays latched while the ring moves on; wrong sequence reads nothing
    task automatic test_snapshot_chunks();
        send_command(OP_SNAP, '0, '0, '0, 9'd0, 7'd0, '0);
        send_command(OP_CHUNK, '0, '0, '0, 9'd0, 7'd64, snap_seq);
        send_command(OP_CHUNK, '0, '0, '0, 9'd0, 7'd64, ~snap_seq);
        send_command(OP_PUSH, rand_word(), rand_word(), rand_word(), 9'd0, 7'd0, '0);
        send_command(OP_CHUNK, '0, '0, '0, 9'd2, 7'd127, snap_seq);
        send_command(OP_CHUNK, '0, '0, '0, 9'd4, 7'd64, snap_seq);
    endtask

    // undecoded opcodes change nothing; clear zeroes every counter
    task automatic test_spare_and_clear();
        logic [2:0] code;
        for (code = OP_SPARE_FIRST; code != OP_PUSH; code++)
            send_command(code, '1, '1, '1, 9'd0, 7'd64, snap_seq);
        send_command(OP_CLEAR, '0, '0, '0, 9'd0, 7'd0, '0);
        send_command(OP_READ, '0, '0, '0, 9'd0, 7'd64, '0);
        send_command(OP_CHUNK, '0, '0, '0, 9'd0, 7'd64, 32'd0);
    endtask

    // mostly pushes until the ring is full and the head has wrapped,
    // with reads, snapshots and chunk reads interleaved
    task automatic test_ring_wrap();
        while (push_seq < WRAP_PUSHES)
            send_random_command(92, 1'b0);
    endtask

    // every command kind at random, clears included
    task automatic test_random_mix();
        repeat (MIX_COMMANDS)
            send_random_command(45, 1'b1);
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_PUSH;
        m_tready = 1'b0;
        calm     = 1'b0;

        ring_head = 0;
        ring_held = 0;
        push_seq  = '0;
        snap_held = 0;
        snap_seq  = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_ring();
        test_push_extremes();
        test_read_limits();
        calm = 1'b1;
        test_snapshot_chunks();
        calm = 1'b0;
        test_spare_and_clear();
        test_ring_wrap();
        test_random_mix();

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d commands: %0d pushes, %0d reads, %0d snapshots, %0d clears;",
                 command_count, push_total, read_total, snap_total, clear_total);
        $display("checked %0d results (%0d samples), head wrapped %0d times, %0d mismatches",
                 results_seen, samples_seen, wrap_total, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
